/* sv/sat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types, constants and the object size table for the sprite
// attribute table.
// ----------------------------------------------------------------------------
package sat_pkg;

   localparam int SPRITE_COUNT = 128;
   localparam int IDX_W        = $clog2(SPRITE_COUNT);
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [7:0] Y_RESET = 8'hF0;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_OBJ_SIZE_SEL = 3'd0
   } csr_addr_type;

   // One sprite as held in the table.
   typedef struct packed {
      logic       is_large;
      logic [8:0] x;
      logic [7:0] y;
      logic [8:0] tile;
      logic [2:0] palette;
      logic [1:0] prio;
      logic       flip_h;
      logic       flip_v;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      is_large: 1'b0, x: 9'd0, y: Y_RESET, tile: 9'd0,
      palette: 3'd0, prio: 2'd0, flip_h: 1'b0, flip_v: 1'b0
   };

   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic [IDX_W-1:0] idx;
   } mem_cmd_type;

   typedef struct packed {
      logic [6:0] width;
      logic [6:0] height;
   } size_type;

   // Small/large width and height for each object size select.
   function automatic size_type size_lookup(input logic [2:0] sel, input logic use_large);
      size_type s;
      unique case (sel)
         3'd0: s = use_large ? size_type'{7'd16, 7'd16} : size_type'{7'd8,  7'd8};
         3'd1: s = use_large ? size_type'{7'd32, 7'd32} : size_type'{7'd8,  7'd8};
         3'd2: s = use_large ? size_type'{7'd64, 7'd64} : size_type'{7'd8,  7'd8};
         3'd3: s = use_large ? size_type'{7'd32, 7'd32} : size_type'{7'd16, 7'd16};
         3'd4: s = use_large ? size_type'{7'd64, 7'd64} : size_type'{7'd16, 7'd16};
         3'd5: s = use_large ? size_type'{7'd64, 7'd64} : size_type'{7'd32, 7'd32};
         3'd6: s = use_large ? size_type'{7'd32, 7'd64} : size_type'{7'd16, 7'd32};
         3'd7: s = use_large ? size_type'{7'd32, 7'd32} : size_type'{7'd16, 7'd32};
         default: s = size_type'{7'd0, 7'd0};
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

/* sv/sat_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sat_req_if / sat_rsp_if
// Valid/ready channels carrying sprite table requests and results.
// ----------------------------------------------------------------------------
interface sat_req_if;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [7:0]        sprite_num;
   logic signed [8:0] x_position;
   logic [7:0]        y_position;
   logic [8:0]        tile_value;
   logic [2:0]        palette_value;
   logic [1:0]        priority_value;
   logic              flip_h_in;
   logic              flip_v_in;
   logic [6:0]        want_width;
   logic [6:0]        want_height;

   modport source (output valid, opcode, sprite_num, x_position, y_position, tile_value,
                   palette_value, priority_value, flip_h_in, flip_v_in, want_width,
                   want_height, input ready);
   modport sink (input valid, opcode, sprite_num, x_position, y_position, tile_value,
                 palette_value, priority_value, flip_h_in, flip_v_in, want_width,
                 want_height, output ready);
endinterface

interface sat_rsp_if;
   logic              valid;
   logic              ready;
   logic              ok;
   logic signed [8:0] sprite_x;
   logic [7:0]        sprite_y;
   logic [8:0]        sprite_tile;
   logic [2:0]        sprite_palette;
   logic [1:0]        sprite_priority;
   logic              flip_h_out;
   logic              flip_v_out;
   logic              large_out;
   logic [6:0]        sprite_width;
   logic [6:0]        sprite_height;

   modport source (output valid, ok, sprite_x, sprite_y, sprite_tile, sprite_palette,
                   sprite_priority, flip_h_out, flip_v_out, large_out, sprite_width,
                   sprite_height, input ready);
   modport sink (input valid, ok, sprite_x, sprite_y, sprite_tile, sprite_palette,
                 sprite_priority, flip_h_out, flip_v_out, large_out, sprite_width,
                 sprite_height, output ready);
endinterface
`default_nettype wire

/* sv/sat_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sat_store
// Sprite entry memory with a registered read and per-entry valid
// bits; an entry never written reads as its reset value.
// ----------------------------------------------------------------------------
module sat_store (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sat_pkg::mem_cmd_type cmd,
   input  wire sat_pkg::entry_type   wr_data,
   output sat_pkg::entry_type        rd_data
);

   sat_pkg::entry_type               mem [sat_pkg::SPRITE_COUNT];
   logic [sat_pkg::SPRITE_COUNT-1:0] valid_ff;
   sat_pkg::entry_type               rd_raw_ff;
   logic                             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.idx] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_raw_ff <= mem[cmd.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[cmd.idx] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.idx];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : sat_pkg::ENTRY_RESET;

endmodule
`default_nettype wire

/* sv/sprite_attribute_table_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_attribute_table_top
// Sprite attribute table: reads decode one sprite with its size, writes
// check the requested size against both selected pairs and store the sprite.
// ----------------------------------------------------------------------------
// Timing: the memory read register loads at the accepting edge, the result
//   register at a later edge once it is free.
// Throughput: one request per cycle, set by the single memory port,
//   while the result channel is not stalled.
// Reset: per-sprite valid bits clear at once, so the table reads as its
//   initial contents right after reset; no clearing pass.
// ----------------------------------------------------------------------------
module sprite_attribute_table_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   sat_req_if.sink                                req_chan,
   sat_rsp_if.source                              rsp_chan,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [sat_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [sat_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [sat_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   // ---------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------
   logic [2:0] size_sel_ff;
   logic [2:0] size_sel_in;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      size_sel_in = size_sel_ff;
      if (csr_write && paddr == sat_pkg::REG_OBJ_SIZE_SEL) begin
         size_sel_in = pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_sel_ff <= 3'd0;
      end else begin
         size_sel_ff <= size_sel_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == sat_pkg::REG_OBJ_SIZE_SEL) begin
         prdata[2:0] = size_sel_ff;
      end
   end

   // ---------------------------------------------------------------
   // Request stage: range and size checks, issue the memory access
   // ---------------------------------------------------------------
   logic                 accept;
   logic                 req_ready;
   logic                 in_range;
   logic                 small_hit;
   logic                 large_hit;
   logic                 wr_ok;
   logic                 is_write;
   sat_pkg::size_type    small_size;
   sat_pkg::size_type    large_size;
   sat_pkg::mem_cmd_type mem_cmd;
   sat_pkg::entry_type   wr_entry;
   sat_pkg::entry_type   rd_entry;

   // Stage 1 bookkeeping (memory read in flight or write acknowledged).
   logic s1_valid_ff, s1_valid_in;
   logic s1_write_ff, s1_write_in;
   logic s1_ok_ff,    s1_ok_in;
   logic s1_advance;

   // Result register.
   logic rsp_valid_ff, rsp_valid_in;

   assign is_write   = (req_chan.opcode == sat_pkg::OP_WRITE);
   assign in_range   = (req_chan.sprite_num < 8'(sat_pkg::SPRITE_COUNT));
   assign small_size = sat_pkg::size_lookup(size_sel_ff, 1'b0);
   assign large_size = sat_pkg::size_lookup(size_sel_ff, 1'b1);
   assign small_hit  = (req_chan.want_width == small_size.width) &&
                       (req_chan.want_height == small_size.height);
   assign large_hit  = (req_chan.want_width == large_size.width) &&
                       (req_chan.want_height == large_size.height);
   assign wr_ok      = in_range && (small_hit || large_hit);

   // Advance stage 1 into the result register whenever that register frees up.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   always_comb begin
      mem_cmd.idx   = req_chan.sprite_num[sat_pkg::IDX_W-1:0];
      mem_cmd.wr_en = accept && is_write && wr_ok;
      mem_cmd.rd_en = accept && !is_write && in_range;
   end

   // Pack the request; small wins when both pairs match.
   always_comb begin
      wr_entry.is_large = !small_hit;
      wr_entry.x        = $unsigned(req_chan.x_position);
      wr_entry.y        = req_chan.y_position;
      wr_entry.tile     = req_chan.tile_value;
      wr_entry.palette  = req_chan.palette_value;
      wr_entry.prio     = req_chan.priority_value;
      wr_entry.flip_h   = req_chan.flip_h_in;
      wr_entry.flip_v   = req_chan.flip_v_in;
   end

   sat_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .wr_data (wr_entry),
      .rd_data (rd_entry)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_write_in = s1_write_ff;
      s1_ok_in    = s1_ok_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_write_in = is_write;
         s1_ok_in    = is_write ? wr_ok : in_range;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_write_ff <= s1_write_in;
      s1_ok_ff    <= s1_ok_in;
   end

   // ---------------------------------------------------------------
   // Decode stage: unpack the read entry into the result register
   // ---------------------------------------------------------------
   sat_pkg::size_type rd_size;
   logic              show_fields;

   assign rd_size     = sat_pkg::size_lookup(size_sel_ff, rd_entry.is_large);
   assign show_fields = !s1_write_ff && s1_ok_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload until the next result moves in; zero every field but ok
   // on writes and failed reads.
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_chan.ok              <= s1_ok_ff;
         rsp_chan.sprite_x        <= show_fields ? $signed(rd_entry.x) : 9'sd0;
         rsp_chan.sprite_y        <= show_fields ? rd_entry.y : 8'd0;
         rsp_chan.sprite_tile     <= show_fields ? rd_entry.tile : 9'd0;
         rsp_chan.sprite_palette  <= show_fields ? rd_entry.palette : 3'd0;
         rsp_chan.sprite_priority <= show_fields ? rd_entry.prio : 2'd0;
         rsp_chan.flip_h_out      <= show_fields && rd_entry.flip_h;
         rsp_chan.flip_v_out      <= show_fields && rd_entry.flip_v;
         rsp_chan.large_out       <= show_fields && rd_entry.is_large;
         rsp_chan.sprite_width    <= show_fields ? rd_size.width : 7'd0;
         rsp_chan.sprite_height   <= show_fields ? rd_size.height : 7'd0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* tb/sv/sat_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_tb_pkg
// Request and result records and a scoreboard that keeps its own copy of
// the sprite table and size selection to predict every result.
// ----------------------------------------------------------------------------
package sat_tb_pkg;
   import sat_pkg::*;

   typedef struct packed {
      op_type            opcode;
      logic [7:0]        sprite_num;
      logic signed [8:0] x_position;
      logic [7:0]        y_position;
      logic [8:0]        tile_value;
      logic [2:0]        palette_value;
      logic [1:0]        priority_value;
      logic              flip_h_in;
      logic              flip_v_in;
      logic [6:0]        want_width;
      logic [6:0]        want_height;
   } sprite_request_type;

   typedef struct packed {
      logic              ok;
      logic signed [8:0] sprite_x;
      logic [7:0]        sprite_y;
      logic [8:0]        sprite_tile;
      logic [2:0]        sprite_palette;
      logic [1:0]        sprite_priority;
      logic              flip_h_out;
      logic              flip_v_out;
      logic              large_out;
      logic [6:0]        sprite_width;
      logic [6:0]        sprite_height;
   } sprite_result_type;

   // Small and large sprite dimensions per size selection.
   localparam logic [6:0] SMALL_WIDTH  [8] = '{7'd8, 7'd8, 7'd8, 7'd16,
                                               7'd16, 7'd32, 7'd16, 7'd16};
   localparam logic [6:0] SMALL_HEIGHT [8] = '{7'd8, 7'd8, 7'd8, 7'd16,
                                               7'd16, 7'd32, 7'd32, 7'd32};
   localparam logic [6:0] LARGE_WIDTH  [8] = '{7'd16, 7'd32, 7'd64, 7'd32,
                                               7'd64, 7'd64, 7'd32, 7'd32};
   localparam logic [6:0] LARGE_HEIGHT [8] = '{7'd16, 7'd32, 7'd64, 7'd32,
                                               7'd64, 7'd64, 7'd64, 7'd32};

   class sprite_table_scoreboard;
      entry_type         sprites [SPRITE_COUNT];
      logic [2:0]        size_sel;
      sprite_result_type pending_results [$];
      int                errors;
      int                reads;
      int                writes;
      int                rejects;
      int                results_checked;

      function new();
         foreach (sprites[i]) begin
            sprites[i]   = '0;
            sprites[i].y = 8'hF0;
         end
         size_sel        = 3'd0;
         errors          = 0;
         reads           = 0;
         writes          = 0;
         rejects         = 0;
         results_checked = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Decode or store one sprite and return what the table must answer.
      function sprite_result_type predict_access(sprite_request_type r);
         sprite_result_type res;
         entry_type         e;
         logic [6:0]        sw, sh, lw, lh;
         res = '0;
         sw  = SMALL_WIDTH[size_sel];
         sh  = SMALL_HEIGHT[size_sel];
         lw  = LARGE_WIDTH[size_sel];
         lh  = LARGE_HEIGHT[size_sel];
         if (r.sprite_num >= SPRITE_COUNT) return res;
         if (r.opcode == OP_READ) begin
            e                   = sprites[r.sprite_num[IDX_W-1:0]];
            res.ok              = 1'b1;
            res.sprite_x        = e.x;
            res.sprite_y        = e.y;
            res.sprite_tile     = e.tile;
            res.sprite_palette  = e.palette;
            res.sprite_priority = e.prio;
            res.flip_h_out      = e.flip_h;
            res.flip_v_out      = e.flip_v;
            res.large_out       = e.is_large;
            res.sprite_width    = e.is_large ? lw : sw;
            res.sprite_height   = e.is_large ? lh : sh;
            return res;
         end
         // Prefer the small pair; a size matching neither pair leaves the table alone.
         if (r.want_width == sw && r.want_height == sh) begin
            e.is_large = 1'b0;
         end else if (r.want_width == lw && r.want_height == lh) begin
            e.is_large = 1'b1;
         end else begin
            return res;
         end
         e.x       = r.x_position;
         e.y       = r.y_position;
         e.tile    = r.tile_value;
         e.palette = r.palette_value;
         e.prio    = r.priority_value;
         e.flip_h  = r.flip_h_in;
         e.flip_v  = r.flip_v_in;
         sprites[r.sprite_num[IDX_W-1:0]] = e;
         res.ok = 1'b1;
         return res;
      endfunction

      task note_request(sprite_request_type r);
         sprite_result_type res;
         res = predict_access(r);
         if (r.opcode == OP_READ) reads++;
         else writes++;
         if (!res.ok) rejects++;
         pending_results.push_back(res);
      endtask

      task report_mismatch(string msg);
         errors++;
         $display("MISMATCH: %s", msg);
      endtask

      task compare_field(string name, logic [15:0] got_v, logic [15:0] want_v);
         if (got_v !== want_v)
            report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                      results_checked, name, got_v, want_v));
      endtask

      task check_result(sprite_result_type got);
         sprite_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result arrived with no request outstanding");
            return;
         end
         want = pending_results.pop_front();
         results_checked++;
         compare_field("ok", got.ok, want.ok);
         compare_field("sprite_x", got.sprite_x, want.sprite_x);
         compare_field("sprite_y", got.sprite_y, want.sprite_y);
         compare_field("sprite_tile", got.sprite_tile, want.sprite_tile);
         compare_field("sprite_palette", got.sprite_palette, want.sprite_palette);
         compare_field("sprite_priority", got.sprite_priority, want.sprite_priority);
         compare_field("flip_h_out", got.flip_h_out, want.flip_h_out);
         compare_field("flip_v_out", got.flip_v_out, want.flip_v_out);
         compare_field("large_out", got.large_out, want.large_out);
         compare_field("sprite_width", got.sprite_width, want.sprite_width);
         compare_field("sprite_height", got.sprite_height, want.sprite_height);
      endtask
   endclass

endpackage

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives reads and writes of the sprite attribute table under every size
// selection and several idle patterns, checking each result on arrival.
// ----------------------------------------------------------------------------
module tb;
   import sat_pkg::*;
   import sat_tb_pkg::*;

   localparam int              WATCHDOG_LIMIT  = 4000;
   localparam int              ITEMS_PER_PHASE = 190;
   localparam int              SETTLE_CYCLES   = 10;
   // Byte address of a register slot that does not exist.
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
   // Size selections visited, one per phase; both extremes included.
   localparam logic [2:0]      SEL_ORDER [8] = '{3'd0, 3'd7, 3'd3, 3'd6,
                                                 3'd2, 3'd5, 3'd1, 3'd4};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int                    req_idle_pct  = 0;
   int                    rsp_stall_pct = 0;
   int                    quiet_cycles  = 0;

   sprite_table_scoreboard sb;

   sat_req_if req_bus ();
   sat_rsp_if rsp_bus ();

   sprite_attribute_table_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result channel at the current phase's rate; hold ready low at start.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Record every accepted request and check every accepted result. Values read
   // here are the ones that stood before this edge.
   always @(posedge clock) begin : monitor
      sprite_request_type seen_req;
      sprite_result_type  seen_rsp;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen_req.opcode         = op_type'(req_bus.opcode);
            seen_req.sprite_num     = req_bus.sprite_num;
            seen_req.x_position     = req_bus.x_position;
            seen_req.y_position     = req_bus.y_position;
            seen_req.tile_value     = req_bus.tile_value;
            seen_req.palette_value  = req_bus.palette_value;
            seen_req.priority_value = req_bus.priority_value;
            seen_req.flip_h_in      = req_bus.flip_h_in;
            seen_req.flip_v_in      = req_bus.flip_v_in;
            seen_req.want_width     = req_bus.want_width;
            seen_req.want_height    = req_bus.want_height;
            sb.note_request(seen_req);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.ok              = rsp_bus.ok;
            seen_rsp.sprite_x        = rsp_bus.sprite_x;
            seen_rsp.sprite_y        = rsp_bus.sprite_y;
            seen_rsp.sprite_tile     = rsp_bus.sprite_tile;
            seen_rsp.sprite_palette  = rsp_bus.sprite_palette;
            seen_rsp.sprite_priority = rsp_bus.sprite_priority;
            seen_rsp.flip_h_out      = rsp_bus.flip_h_out;
            seen_rsp.flip_v_out      = rsp_bus.flip_v_out;
            seen_rsp.large_out       = rsp_bus.large_out;
            seen_rsp.sprite_width    = rsp_bus.sprite_width;
            seen_rsp.sprite_height   = rsp_bus.sprite_height;
            sb.check_result(seen_rsp);
         end
      end
   end

   // Drop the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sprite_attribute_table_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic sprite_request_type make_request(
      input op_type op, input int idx, input int x, input int y, input int tile,
      input int pal, input int prio, input int fh, input int fv, input int w, input int h);
      sprite_request_type r;
      r.opcode         = op;
      r.sprite_num     = 8'(idx);
      r.x_position     = 9'(x);
      r.y_position     = 8'(y);
      r.tile_value     = 9'(tile);
      r.palette_value  = 3'(pal);
      r.priority_value = 2'(prio);
      r.flip_h_in      = 1'(fh);
      r.flip_v_in      = 1'(fv);
      r.want_width     = 7'(w);
      r.want_height    = 7'(h);
      return r;
   endfunction

   // Mostly in-range sprites with sizes that fit the current selection; the rest
   // are out-of-range indexes and sizes that mostly fit neither pair.
   function automatic sprite_request_type random_request();
      sprite_request_type r;
      logic [2:0]         sel;
      int                 pick;
      sel              = sb.size_sel;
      r.opcode         = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      r.sprite_num     = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(128, 255))
                                                      : 8'($urandom_range(0, 127));
      r.x_position     = 9'($urandom);
      r.y_position     = 8'($urandom);
      r.tile_value     = 9'($urandom);
      r.palette_value  = 3'($urandom);
      r.priority_value = 2'($urandom);
      r.flip_h_in      = 1'($urandom);
      r.flip_v_in      = 1'($urandom);
      pick             = $urandom_range(0, 99);
      if (pick < 45) begin
         r.want_width  = SMALL_WIDTH[sel];
         r.want_height = SMALL_HEIGHT[sel];
      end else if (pick < 90) begin
         r.want_width  = LARGE_WIDTH[sel];
         r.want_height = LARGE_HEIGHT[sel];
      end else if (pick < 95) begin
         r.want_width  = 7'($urandom);
         r.want_height = 7'($urandom);
      end else begin
         // Mix the pairs: usually a bad size, but under some selections a valid one.
         r.want_width  = SMALL_WIDTH[sel];
         r.want_height = LARGE_HEIGHT[sel];
      end
      return r;
   endfunction

   // Present one request after a random idle gap and hold it until accepted.
   task automatic drive_request(input sprite_request_type r);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.opcode         <= r.opcode;
      req_bus.sprite_num     <= r.sprite_num;
      req_bus.x_position     <= r.x_position;
      req_bus.y_position     <= r.y_position;
      req_bus.tile_value     <= r.tile_value;
      req_bus.palette_value  <= r.palette_value;
      req_bus.priority_value <= r.priority_value;
      req_bus.flip_h_in      <= r.flip_h_in;
      req_bus.flip_v_in      <= r.flip_v_in;
      req_bus.want_width     <= r.want_width;
      req_bus.want_height    <= r.want_height;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stop sending and wait for every outstanding result.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Setup then access; the register takes the value on the access edge.
   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == REG_OBJ_SIZE_SEL) sb.size_sel = data[2:0];
      @(posedge clock);
   endtask

   task automatic check_size_select(input logic [2:0] expected);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= REG_OBJ_SIZE_SEL;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {29'd0, expected})
         sb.report_mismatch($sformatf("size select reads 0x%0h, expected 0x%0h",
                                      prdata, expected));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      sb = new();
      // Hold every input at a known value through reset.
      reset                  <= 1'b1;
      psel                   <= 1'b0;
      penable                <= 1'b0;
      pwrite                 <= 1'b0;
      paddr                  <= REG_OBJ_SIZE_SEL;
      pwdata                 <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.opcode         <= OP_READ;
      req_bus.sprite_num     <= '0;
      req_bus.x_position     <= '0;
      req_bus.y_position     <= '0;
      req_bus.tile_value     <= '0;
      req_bus.palette_value  <= '0;
      req_bus.priority_value <= '0;
      req_bus.flip_h_in      <= 1'b0;
      req_bus.flip_v_in      <= 1'b0;
      req_bus.want_width     <= '0;
      req_bus.want_height    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset selection (8x8 small, 16x16 large).
      // Read the reset table at both ends, then indexes past the table.
      drive_request(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_request(make_request(OP_READ, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_request(make_request(OP_READ, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_request(make_request(OP_READ, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Store field maxima as a small sprite, then minima as a large one; x, being signed, goes the other way.
      drive_request(make_request(OP_WRITE, 5, -256, 255, 511, 7, 3, 1, 1, 8, 8));
      drive_request(make_request(OP_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_request(make_request(OP_WRITE, 5, 255, 0, 0, 0, 0, 0, 0, 16, 16));
      drive_request(make_request(OP_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Reject a size that fits neither pair; the sprite must stay as it was.
      drive_request(make_request(OP_WRITE, 5, 1, 2, 3, 4, 1, 1, 0, 8, 16));
      drive_request(make_request(OP_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Reject a write past the table.
      drive_request(make_request(OP_WRITE, 200, 9, 9, 9, 1, 1, 0, 0, 8, 8));
      drive_request(make_request(OP_WRITE, 127, -1, 'h5A, 'h100, 5, 2, 1, 0, 16, 16));
      drive_request(make_request(OP_READ, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_request(make_request(OP_WRITE, 6, 3, 3, 3, 3, 3, 1, 1, 127, 127));
      drive_request(make_request(OP_WRITE, 6, 3, 3, 3, 3, 3, 1, 1, 0, 0));
      // Neighbors are separate entries; a write must touch only its own sprite.
      drive_request(make_request(OP_WRITE, 4, 1, 'hA5, 'h0FF, 2, 1, 0, 1, 8, 8));
      drive_request(make_request(OP_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_request(make_request(OP_READ, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_request(make_request(OP_WRITE, 7, -2, 'h10, 'h1C3, 6, 0, 0, 1, 16, 16));
      drive_request(make_request(OP_READ, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_request(make_request(OP_READ, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      wait_drained();

      // A write to an unmapped slot must leave the size selection alone.
      write_register(UNMAPPED_ADDR, 32'h0000_0005);
      check_size_select(3'd0);

      // Random phases: one size selection each, cycling through the idle patterns.
      for (int p = 0; p < 8; p++) begin
         wait_drained();
         write_register(REG_OBJ_SIZE_SEL, {29'($urandom), SEL_ORDER[p]});
         check_size_select(SEL_ORDER[p]);
         case (p % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 76;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 76;
            end
            default: begin
               req_idle_pct  = 19;
               rsp_stall_pct = 19;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Halfway through a stalled phase, hold off until the table is idle.
            if (p == 2 && n == ITEMS_PER_PHASE / 2) wait_drained();
            drive_request(random_request());
         end
      end

      // Drain, then allow the pipeline latency for any stray result.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

      $display("Run covered %0d reads and %0d writes (%0d rejected) over 8 size selections",
               sb.reads, sb.writes, sb.rejects);
      $display("and four idle patterns; %0d results checked, %0d mismatches.",
               sb.results_checked, sb.errors);
      if (sb.errors == 0) begin
         $display("sprite_attribute_table_top verification clean");
      end else begin
         $display("sprite_attribute_table_top verification failed");
      end
      $finish;
   end

endmodule
